// File: rtl/core/drs_pkg.sv
// shared types and constants for the delivery rate sampler
// no dependencies; imported by every module of the block
package drs_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int BYTE_BITS     = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_ADDR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int DIV_CNT_BITS  = $clog2(BYTE_BITS);

    localparam logic [BYTE_BITS-1:0] BYTES_MAX  = {BYTE_BITS{1'b1}};
    localparam logic [BYTE_BITS-1:0] RATE_SCALE = 64'd1000;
    localparam logic [BYTE_BITS-1:0] RATE_LIMIT = BYTES_MAX / RATE_SCALE;

    typedef enum logic [1:0] {
        OP_SEND  = 2'd0,
        OP_ACK   = 2'd1,
        OP_MARK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/core/delivery_rate_sampler.sv
// delivery rate sampler top level
// connects drs_front, drs_queue and drs_back; uses drs_pkg
//
// input channel s_axis: tuser carries the op (send, ack, mark app limited,
// clear); tdata carries the packet fields. mark and clear update state and
// produce no output transaction. send and ack each produce one transaction
// on m_axis, with tuser holding the kind (send snapshot or ack sample).
// the front end takes one item per cycle while the 4-entry job queue has
// room and updates the counters at once. the back end works one job at a
// time: a send, or an ack without a rate, passes through the queue and the
// states delta, scale and done before it appears on m_axis; an ack that
// yields a rate also passes through the 64-step restoring divider (one
// quotient bit per cycle) between scale and done.
// reset (i_rst_n low, synchronous) clears the counters, the flag, the queue
// and the output valid bit. when m_axis_tready is low the result holds in the
// output register, the back end finishes its next job and waits, and
// s_axis_tready drops once the queue is full.
module delivery_rate_sampler #(
    parameter int TIME_BITS = drs_pkg::TIME_BITS_DEF,
    localparam int IN_BITS     = 3 * TIME_BITS + 2 * drs_pkg::BYTE_BITS + 2,
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS    = 4 * TIME_BITS + 3 * drs_pkg::BYTE_BITS + 2,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // now, acked, pkt_bytes, pkt_time, pkt_first_sent, pkt_limited,
    // pkt_retx
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // total_bytes, stamp, first_sent, limited, prior_bytes, rtt_valid,
    // rtt, gap, rate
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic                   m_axis_tuser
);
    import drs_pkg::*;

    localparam int JOB_W = 4 * TIME_BITS + 3 * BYTE_BITS + 3;
    localparam int T     = TIME_BITS;
    localparam int B     = BYTE_BITS;

    logic             push, pop;
    logic [JOB_W-1:0] job_in, job_out;
    t_q_stat          q_stat;

    drs_front #(
        .TIME_BITS (TIME_BITS),
        .JOB_W     (JOB_W)
    ) u_front (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (s_axis_tvalid),
        .o_ready                 (s_axis_tready),
        .i_op                    (t_op'(s_axis_tuser)),
        .i_now_ms                (s_axis_tdata[T-1:0]),
        .i_acked_bytes           (s_axis_tdata[T+B-1:T]),
        .i_pkt_delivered_bytes   (s_axis_tdata[T+2*B-1:T+B]),
        .i_pkt_delivered_time_ms (s_axis_tdata[2*T+2*B-1:T+2*B]),
        .i_pkt_first_sent_ms     (s_axis_tdata[3*T+2*B-1:2*T+2*B]),
        .i_pkt_app_limited       (s_axis_tdata[3*T+2*B]),
        .i_pkt_retransmitted     (s_axis_tdata[3*T+2*B+1]),
        .i_q_stat                (q_stat),
        .o_push                  (push),
        .o_job                   (job_in)
    );

    drs_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_stat  (q_stat)
    );

    drs_back #(
        .TIME_BITS   (TIME_BITS),
        .JOB_W       (JOB_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_kind   (m_axis_tuser)
    );

endmodule

// File: rtl/core/drs_front.sv
// front end: accepts items, keeps the delivered count, time and limited flag
// builds one job record per send or ack; uses drs_pkg
module drs_front #(
    parameter int TIME_BITS = drs_pkg::TIME_BITS_DEF,
    parameter int JOB_W     = 4 * TIME_BITS + 3 * drs_pkg::BYTE_BITS + 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  drs_pkg::t_op                  i_op,
    input  logic [TIME_BITS-1:0]          i_now_ms,
    input  logic [drs_pkg::BYTE_BITS-1:0] i_acked_bytes,
    input  logic [drs_pkg::BYTE_BITS-1:0] i_pkt_delivered_bytes,
    input  logic [TIME_BITS-1:0]          i_pkt_delivered_time_ms,
    input  logic [TIME_BITS-1:0]          i_pkt_first_sent_ms,
    input  logic                          i_pkt_app_limited,
    input  logic                          i_pkt_retransmitted,
    input  drs_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output logic [JOB_W-1:0]              o_job
);
    import drs_pkg::*;

    typedef struct packed {
        logic                  kind;
        logic [BYTE_BITS-1:0]  delivered;
        logic [TIME_BITS-1:0]  dtime;
        logic [TIME_BITS-1:0]  first_sent;
        logic                  limited;
        logic [BYTE_BITS-1:0]  prior;
        logic                  rtt_valid;
        logic [TIME_BITS-1:0]  rtt;
        logic [TIME_BITS-1:0]  interval;
        logic [BYTE_BITS-1:0]  pkt_bytes;
    } t_job;

    logic [BYTE_BITS-1:0] r_total, n_total;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic                 r_limited, n_limited;

    logic                 acc;
    logic [BYTE_BITS-1:0] sum_total;
    logic                 rtt_ok;
    logic [TIME_BITS-1:0] interval_raw;
    t_job                 job;

    assign o_ready   = !i_q_stat.full;
    assign acc       = i_valid && o_ready;
    assign sum_total = r_total + i_acked_bytes;
    assign rtt_ok    = !i_pkt_retransmitted && (i_now_ms >= i_pkt_first_sent_ms);
    assign interval_raw = (i_now_ms > i_pkt_delivered_time_ms) ?
                          (i_now_ms - i_pkt_delivered_time_ms) : '0;

    always_comb begin
        job = '0;
        unique case (i_op)
            OP_SEND: begin
                job.kind        = KIND_SEND;
                job.delivered   = r_total;
                job.dtime       = r_last;
                job.first_sent  = (i_pkt_first_sent_ms == '0) ? i_now_ms
                                                              : i_pkt_first_sent_ms;
                job.limited     = r_limited;
            end
            OP_ACK: begin
                job.kind        = KIND_ACK;
                job.delivered   = sum_total;
                job.dtime       = i_now_ms;
                job.limited     = i_pkt_app_limited;
                job.prior       = r_total;
                job.rtt_valid   = rtt_ok;
                job.rtt         = rtt_ok ? (i_now_ms - i_pkt_first_sent_ms) : '0;
                job.interval    = rtt_ok ? interval_raw : '0;
                job.pkt_bytes   = i_pkt_delivered_bytes;
            end
            default: begin
                job = '0;
            end
        endcase
    end

    assign o_job  = job;
    assign o_push = acc && ((i_op == OP_SEND) || (i_op == OP_ACK));

    always_comb begin
        n_total   = r_total;
        n_last    = r_last;
        n_limited = r_limited;
        if (acc) begin
            unique case (i_op)
                OP_SEND: begin
                end
                OP_ACK: begin
                    n_total = sum_total;
                    n_last  = i_now_ms;
                end
                OP_MARK: begin
                    n_limited = 1'b1;
                end
                OP_CLEAR: begin
                    n_total   = '0;
                    n_last    = '0;
                    n_limited = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_last    <= '0;
            r_limited <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_last    <= n_last;
            r_limited <= n_limited;
        end
    end

endmodule

// File: rtl/core/drs_queue.sv
// short job queue between front and back end, first word fall through
// uses drs_pkg for depth and status type
module drs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output drs_pkg::t_q_stat o_stat
);
    import drs_pkg::*;

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [Q_ADDR_BITS-1:0] r_wr, n_wr;
    logic [Q_ADDR_BITS-1:0] r_rd, n_rd;
    logic [Q_ADDR_BITS:0]   r_cnt, n_cnt;
    logic                   do_push, do_pop;

    assign o_stat.full  = (r_cnt == (Q_ADDR_BITS+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= (Q_ADDR_BITS+1)'(QUEUE_DEPTH)))
        else $error("queue count past depth");

endmodule

// File: rtl/core/drs_back.sv
// back end: byte delta, rate scaling, restoring divider and output register
// takes job records from drs_queue; uses drs_pkg
module drs_back #(
    parameter int TIME_BITS   = drs_pkg::TIME_BITS_DEF,
    parameter int JOB_W       = 4 * TIME_BITS + 3 * drs_pkg::BYTE_BITS + 3,
    parameter int OUT_TDATA_W = ((4 * TIME_BITS + 3 * drs_pkg::BYTE_BITS + 2 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  drs_pkg::t_q_stat       i_q_stat,
    input  logic [JOB_W-1:0]       i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data,
    output logic                   o_kind
);
    import drs_pkg::*;

    localparam int OUT_BITS = 4 * TIME_BITS + 3 * BYTE_BITS + 2;

    typedef struct packed {
        logic                  kind;
        logic [BYTE_BITS-1:0]  delivered;
        logic [TIME_BITS-1:0]  dtime;
        logic [TIME_BITS-1:0]  first_sent;
        logic                  limited;
        logic [BYTE_BITS-1:0]  prior;
        logic                  rtt_valid;
        logic [TIME_BITS-1:0]  rtt;
        logic [TIME_BITS-1:0]  interval;
        logic [BYTE_BITS-1:0]  pkt_bytes;
    } t_job;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DELTA = 5'b00010,
        S_SCALE = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    t_job                    r_job;
    logic [BYTE_BITS-1:0]    r_delta;
    logic [BYTE_BITS-1:0]    r_quo;
    logic [TIME_BITS-1:0]    r_rem;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data;
    logic                    r_m_kind;

    logic [BYTE_BITS-1:0]    delta_raw;
    logic [BYTE_BITS-1:0]    scaled;
    logic [TIME_BITS:0]      trial, trial_diff;
    logic                    trial_ge;
    logic                    out_load;
    logic [OUT_BITS-1:0]     out_word;

    assign delta_raw  = (r_job.delivered >= r_job.pkt_bytes) ?
                        (r_job.delivered - r_job.pkt_bytes) : '0;
    // times 1000 as 1024 - 16 - 8
    assign scaled     = (r_delta << 10) - (r_delta << 4) - (r_delta << 3);
    assign trial      = {r_rem, r_quo[BYTE_BITS-1]};
    assign trial_diff = trial - {1'b0, r_job.interval};
    assign trial_ge   = (trial >= {1'b0, r_job.interval});

    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign out_load = (r_state == S_DONE) && (!r_m_valid || i_ready);

    assign out_word = {r_quo, r_job.interval, r_job.rtt, r_job.rtt_valid, r_job.prior,
                       r_job.limited, r_job.first_sent, r_job.dtime, r_job.delivered};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_stat.empty) n_state = S_DELTA;
            S_DELTA: n_state = S_SCALE;
            S_SCALE: begin
                if ((r_delta == '0) || (r_job.interval == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   if (r_cnt == {DIV_CNT_BITS{1'b1}}) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job <= t_job'(i_job);
            end
            S_DELTA: begin
                r_delta <= delta_raw;
            end
            S_SCALE: begin
                r_rem <= '0;
                r_cnt <= '0;
                if ((r_delta == '0) || (r_job.interval == '0)) begin
                    r_quo <= '0;
                end else if (r_delta > RATE_LIMIT) begin
                    r_quo <= BYTES_MAX;
                end else begin
                    r_quo <= scaled;
                end
            end
            S_DIV: begin
                r_rem <= trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
                r_quo <= {r_quo[BYTE_BITS-2:0], trial_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_m_data <= OUT_TDATA_W'(out_word);
            r_m_kind <= r_job.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_m_valid;
    assign o_data  = r_m_data;
    assign o_kind  = r_m_kind;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == {DIV_CNT_BITS{1'b1}}) |=> (r_state == S_DONE))
        else $error("divider did not finish after last step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_kind == KIND_SEND) |->
        (r_m_data[OUT_BITS-1 -: BYTE_BITS] == '0) &&
        !r_m_data[2*TIME_BITS+2*BYTE_BITS+1])
        else $error("send transaction carries a rate sample");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE && r_job.interval == '0) |=> (r_state == S_DONE && r_quo == '0))
        else $error("zero interval must give zero rate");

endmodule

// File: tb/sv/delivery_rate_sampler_tb.sv
// self-checking testbench for delivery_rate_sampler: directed table, then random
// traffic of sends, acks, marks and clears checked against a cycle-free predictor
// depends on drs_pkg and the delivery_rate_sampler rtl only
module delivery_rate_sampler_tb;
    import drs_pkg::*;

    localparam int TW = TIME_BITS_DEF;
    localparam int BW = BYTE_BITS;
    localparam int IN_W = ((3 * TW + 2 * BW + 2 + 7) / 8) * 8;
    localparam int OUT_W = ((4 * TW + 3 * BW + 2 + 7) / 8) * 8;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    localparam logic [TW-1:0] T_MAX = {TW{1'b1}};
    localparam logic [BW-1:0] B_MAX = {BW{1'b1}};
    localparam logic [BW-1:0] RATE_CAP = B_MAX / 64'd1000;

    typedef struct packed {
        logic [IN_W-(3*TW+2*BW+2)-1:0] pad;
        logic                          retx;
        logic                          app_lim;
        logic [TW-1:0]                 first_sent;
        logic [TW-1:0]                 dtime;
        logic [BW-1:0]                 dbytes;
        logic [BW-1:0]                 acked;
        logic [TW-1:0]                 now;
    } t_pkt_in;

    typedef struct packed {
        logic [OUT_W-(4*TW+3*BW+2)-1:0] pad;
        logic [BW-1:0]                  rate;
        logic [TW-1:0]                  interval;
        logic [TW-1:0]                  rtt;
        logic                           rtt_valid;
        logic [BW-1:0]                  prior;
        logic                           app_lim;
        logic [TW-1:0]                  first_sent;
        logic [TW-1:0]                  dtime;
        logic [BW-1:0]                  dbytes;
    } t_sample_out;

    typedef struct packed {
        logic        kind;
        t_sample_out res;
    } t_sample;

    typedef struct packed {
        logic [BW-1:0] dbytes;
        logic [TW-1:0] dtime;
        logic [TW-1:0] first_sent;
        logic          app_lim;
    } t_pkt_snap;

    typedef struct {
        t_op         op;
        t_pkt_in     item;
        bit          typed;
        logic        kind;
        t_sample_out res;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;   // now, acked, pkt_bytes, pkt_time,
                                          // pkt_first_sent, pkt_limited, pkt_retx
    logic [1:0]           s_axis_tuser;   // op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // total_bytes, stamp, first_sent, limited,
                                          // prior_bytes, rtt_valid, rtt, gap, rate
    logic                 m_axis_tuser;   // kind

    delivery_rate_sampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [BW-1:0] delivered_total;
    logic [TW-1:0] delivery_stamp;
    logic          limited_st;

    t_sample   awaited_samples[$];
    t_pkt_snap inflight_pkts[$];
    t_stim_row directed_rows[$];
    t_stim_row cur_row;

    logic [TW-1:0] conn_ms;
    bit  in_took;
    bit  out_took;
    int  send_pct;
    int  stall_pct;
    int  quiet_cycles;
    int  fail_count;
    int  checked_count;
    int  n_items, n_sends, n_acks, n_rated, n_saturated, n_marks, n_clears;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_pkt_in mk_in(logic [TW-1:0] now, logic [BW-1:0] acked,
                                      logic [BW-1:0] dbytes, logic [TW-1:0] dtime,
                                      logic [TW-1:0] first_sent, logic app_lim, logic retx);
        t_pkt_in it;
        it = '0;
        it.now = now;
        it.acked = acked;
        it.dbytes = dbytes;
        it.dtime = dtime;
        it.first_sent = first_sent;
        it.app_lim = app_lim;
        it.retx = retx;
        return it;
    endfunction

    function automatic t_sample_out mk_out(logic [BW-1:0] dbytes, logic [TW-1:0] dtime,
                                           logic [TW-1:0] first_sent, logic app_lim,
                                           logic [BW-1:0] prior, logic rtt_valid,
                                           logic [TW-1:0] rtt, logic [TW-1:0] interval,
                                           logic [BW-1:0] rate);
        t_sample_out r;
        r = '0;
        r.dbytes = dbytes;
        r.dtime = dtime;
        r.first_sent = first_sent;
        r.app_lim = app_lim;
        r.prior = prior;
        r.rtt_valid = rtt_valid;
        r.rtt = rtt;
        r.interval = interval;
        r.rate = rate;
        return r;
    endfunction

    function automatic void clear_state();
        delivered_total = '0;
        delivery_stamp = '0;
        limited_st = 1'b0;
    endfunction

    function automatic bit predict_sample(input t_op op, input t_pkt_in it,
                                          output logic kind, output t_sample_out res);
        logic [TW-1:0] gap;
        logic [BW-1:0] delta;
        res = '0;
        kind = KIND_SEND;
        n_items++;
        case (op)
            OP_MARK: begin
                limited_st = 1'b1;
                n_marks++;
                return 1'b0;
            end
            OP_CLEAR: begin
                clear_state();
                n_clears++;
                return 1'b0;
            end
            OP_SEND: begin
                res.dbytes = delivered_total;
                res.dtime = delivery_stamp;
                res.first_sent = (it.first_sent == '0) ? it.now : it.first_sent;
                res.app_lim = limited_st;
                n_sends++;
                return 1'b1;
            end
            default: begin
                kind = KIND_ACK;
                n_acks++;
                res.app_lim = it.app_lim;
                res.prior = delivered_total;
                delivered_total = delivered_total + it.acked;
                delivery_stamp = it.now;
                res.dbytes = delivered_total;
                res.dtime = it.now;
                if (!it.retx && it.now >= it.first_sent) begin
                    res.rtt_valid = 1'b1;
                    res.rtt = it.now - it.first_sent;
                    gap = (it.now > it.dtime) ? it.now - it.dtime : '0;
                    if (gap != '0) begin
                        res.interval = gap;
                        delta = (delivered_total > it.dbytes) ? delivered_total - it.dbytes : '0;
                        if (delta == '0) begin
                            res.rate = '0;
                        end else if (delta > RATE_CAP) begin
                            res.rate = B_MAX / {{(BW-TW){1'b0}}, gap};
                            n_saturated++;
                        end else begin
                            res.rate = (delta * 64'd1000) / {{(BW-TW){1'b0}}, gap};
                        end
                        n_rated++;
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic string fld(string name, logic [63:0] e, logic [63:0] a);
        return (e == a) ? "" : $sformatf(" %s exp %h got %h", name, e, a);
    endfunction

    function automatic logic [63:0] skewed_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // transaction monitor, predictor hook, scoreboard and watchdog
    always @(posedge i_clk) begin
        logic        pk;
        t_sample_out pr;
        t_sample     exp_s;
        t_sample_out got;
        string       bad;
        in_took = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_took = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_took) begin
            if (predict_sample(cur_row.op, cur_row.item, pk, pr)) begin
                if (cur_row.typed) begin
                    awaited_samples.push_back({cur_row.kind, cur_row.res});
                end else begin
                    awaited_samples.push_back({pk, pr});
                end
                if (pk == KIND_SEND) begin
                    inflight_pkts.push_back({pr.dbytes, pr.dtime, pr.first_sent, pr.app_lim});
                    if (inflight_pkts.size() > 24) begin
                        void'(inflight_pkts.pop_front());
                    end
                end
            end else if (cur_row.op == OP_CLEAR) begin
                inflight_pkts.delete();
            end
        end
        if (out_took) begin
            got = m_axis_tdata;
            if (awaited_samples.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: kind %0d data %h", m_axis_tuser, got);
                end
            end else begin
                exp_s = awaited_samples.pop_front();
                checked_count++;
                bad = {fld("kind", {63'd0, exp_s.kind}, {63'd0, m_axis_tuser}),
                       fld("total_bytes", exp_s.res.dbytes, got.dbytes),
                       fld("delivered_time", {16'd0, exp_s.res.dtime}, {16'd0, got.dtime}),
                       fld("first_sent", {16'd0, exp_s.res.first_sent}, {16'd0, got.first_sent}),
                       fld("limited", {63'd0, exp_s.res.app_lim}, {63'd0, got.app_lim}),
                       fld("prior_bytes", exp_s.res.prior, got.prior),
                       fld("rtt_valid", {63'd0, exp_s.res.rtt_valid}, {63'd0, got.rtt_valid}),
                       fld("rtt", {16'd0, exp_s.res.rtt}, {16'd0, got.rtt}),
                       fld("interval", {16'd0, exp_s.res.interval}, {16'd0, got.interval}),
                       fld("rate", exp_s.res.rate, got.rate)};
                if (bad != "") begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch on result %0d:%s", checked_count, bad);
                    end
                end
            end
        end
        if (in_took || out_took || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, awaited_samples.size());
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic offer(input t_stim_row row);
        while ($urandom_range(99) < send_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        cur_row = row;
        s_axis_tuser <= row.op;
        s_axis_tdata <= row.item;
        s_axis_tvalid <= 1'b1;
        do @(negedge i_clk); while (!in_took);
    endtask

    task automatic make_random(output t_stim_row s);
        int            pick;
        int            idx;
        t_pkt_snap     sn;
        logic [63:0]   w;
        s.typed = 1'b0;
        s.kind = KIND_SEND;
        s.res = '0;
        s.item = '0;
        conn_ms = conn_ms + {16'd0, $urandom_range(0, 40)};
        pick = $urandom_range(99);
        if (pick < 18) begin
            s.op = t_op'($urandom_range(3));
            w = skewed_word();
            s.item.now = w[TW-1:0];
            s.item.acked = skewed_word();
            s.item.dbytes = skewed_word();
            w = skewed_word();
            s.item.dtime = w[TW-1:0];
            w = skewed_word();
            s.item.first_sent = w[TW-1:0];
            s.item.app_lim = 1'($urandom_range(1));
            s.item.retx = 1'($urandom_range(1));
        end else if (pick < 22) begin
            s.op = OP_MARK;
            s.item.now = conn_ms;
        end else if (pick < 24) begin
            s.op = OP_CLEAR;
            s.item.now = conn_ms;
        end else if (pick < 60 || inflight_pkts.size() == 0) begin
            s.op = OP_SEND;
            s.item.now = conn_ms;
            if ($urandom_range(7) == 0) begin
                s.item.first_sent = conn_ms - {16'd0, $urandom_range(1, 200)};
            end
        end else begin
            idx = ($urandom_range(3) == 0) ? $urandom_range(inflight_pkts.size() - 1) : 0;
            sn = inflight_pkts[idx];
            inflight_pkts.delete(idx);
            s.op = OP_ACK;
            s.item.now = conn_ms;
            case ($urandom_range(19))
                0: s.item.acked = {$urandom, $urandom};
                1, 2: s.item.acked = {32'd0, $urandom};
                default: s.item.acked = {32'd0, $urandom_range(1, 20000)};
            endcase
            s.item.dbytes = sn.dbytes;
            s.item.dtime = sn.dtime;
            s.item.first_sent = sn.first_sent;
            s.item.app_lim = sn.app_lim;
            s.item.retx = ($urandom_range(9) == 0);
        end
    endtask

    initial begin
        t_stim_row row;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_SEND;
        m_axis_tready = 1'b1;
        send_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        fail_count = 0;
        checked_count = 0;
        conn_ms = '0;
        clear_state();

        // send after reset, extremes of first send time
        directed_rows.push_back('{OP_SEND, mk_in(100, 0, 0, 0, 0, 0, 0), 1'b1, KIND_SEND,
                                  mk_out(0, 0, 100, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{OP_SEND, mk_in(5, 0, 0, 0, T_MAX, 0, 0), 1'b1, KIND_SEND,
                                  mk_out(0, 0, T_MAX, 0, 0, 0, 0, 0, 0)});
        // zero delta, then a plain rate, then a retransmitted packet
        directed_rows.push_back('{OP_ACK, mk_in(1000, 0, 0, 0, 0, 1, 0), 1'b1, KIND_ACK,
                                  mk_out(0, 1000, 0, 1, 0, 1, 1000, 1000, 0)});
        directed_rows.push_back('{OP_ACK, mk_in(2000, 5000, 0, 1000, 1500, 0, 0), 1'b1, KIND_ACK,
                                  mk_out(5000, 2000, 0, 0, 0, 1, 500, 1000, 5000)});
        directed_rows.push_back('{OP_ACK, mk_in(3000, 100, 0, 0, 0, 0, 1), 1'b1, KIND_ACK,
                                  mk_out(5100, 3000, 0, 0, 5000, 0, 0, 0, 0)});
        directed_rows.push_back('{OP_SEND, mk_in(3500, 0, 0, 0, 0, 0, 0), 1'b1, KIND_SEND,
                                  mk_out(5100, 3000, 3500, 0, 0, 0, 0, 0, 0)});
        // now before first send, zero interval, interval below zero, delta below snapshot
        directed_rows.push_back('{OP_ACK, mk_in(10, 7, 0, 0, 20, 0, 0), 1'b0, KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(4000, 1500, 5100, 4000, 3900, 0, 0), 1'b0,
                                  KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(4100, 10, 0, 9000, 4000, 0, 0), 1'b0,
                                  KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(5000, 1, B_MAX, 4000, 4500, 1, 0), 1'b0,
                                  KIND_ACK, '0});
        // product right at the limit, then one byte over it, then counter wrap
        directed_rows.push_back('{OP_CLEAR, mk_in(0, 0, 0, 0, 0, 0, 0), 1'b0, KIND_SEND, '0});
        directed_rows.push_back('{OP_ACK, mk_in(100, RATE_CAP, 0, 0, 50, 0, 0), 1'b0,
                                  KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(200, 1, 0, 100, 150, 0, 0), 1'b0, KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(300, B_MAX, 0, 0, 0, 0, 0), 1'b0, KIND_ACK, '0});
        // app limited flag
        directed_rows.push_back('{OP_MARK, mk_in(0, 0, 0, 0, 0, 0, 0), 1'b0, KIND_SEND, '0});
        directed_rows.push_back('{OP_SEND, mk_in(400, 0, 0, 0, 0, 0, 0), 1'b0, KIND_SEND, '0});
        // widest interval, all fields at max, all fields at zero
        directed_rows.push_back('{OP_ACK, mk_in(T_MAX, B_MAX >> 1, 0, 0, 0, 0, 0), 1'b0,
                                  KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(T_MAX, B_MAX, B_MAX, T_MAX, T_MAX, 1, 1), 1'b0,
                                  KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(T_MAX, B_MAX, B_MAX, T_MAX, T_MAX, 1, 0), 1'b0,
                                  KIND_ACK, '0});
        directed_rows.push_back('{OP_ACK, mk_in(0, 0, 0, 0, 0, 0, 0), 1'b0, KIND_ACK, '0});
        directed_rows.push_back('{OP_SEND, mk_in(50, 0, 0, 0, 0, 1, 1), 1'b0, KIND_SEND, '0});
        // clear drops the flag and counters
        directed_rows.push_back('{OP_CLEAR, mk_in(T_MAX, B_MAX, B_MAX, T_MAX, T_MAX, 1, 1), 1'b0,
                                  KIND_SEND, '0});
        directed_rows.push_back('{OP_SEND, mk_in(7, 0, 0, 0, 9, 0, 0), 1'b1, KIND_SEND,
                                  mk_out(0, 0, 9, 0, 0, 0, 0, 0, 0)});
        directed_rows.push_back('{OP_ACK, mk_in(1, 123456789, 0, 0, 1, 0, 0), 1'b0,
                                  KIND_ACK, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i]);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 49; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 49; end
                default: begin send_pct = 37; stall_pct = 37; end
            endcase
            if (ph == 2) begin
                // hold off until the block has drained every result
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                while (awaited_samples.size() != 0) @(negedge i_clk);
                conn_ms = T_MAX - 48'd3000;
            end else begin
                conn_ms = {16'd0, $urandom_range(0, 100000)};
            end
            repeat (RANDOM_PER_PHASE) begin
                make_random(row);
                offer(row);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("ran %0d items: %0d sends, %0d acks (%0d with a rate, %0d saturated), "
                 , n_items, n_sends, n_acks, n_rated, n_saturated);
        $display("%0d marks, %0d clears; %0d results checked, %0d failures",
                 n_marks, n_clears, checked_count, fail_count);
        if (fail_count == 0 && awaited_samples.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
